FILE: design/bitmap_next_fit_allocator_defines.svh
// Assertion macros shared by the allocator RTL.
`ifndef BITMAP_NEXT_FIT_ALLOCATOR_DEFINES_SVH
`define BITMAP_NEXT_FIT_ALLOCATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked check, switched off while reset is high.
`define BNFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds through reset.
`define BNFA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BNFA_ASSERT(lbl, prop, msg)
`define BNFA_ASSERT_RST(lbl, prop, msg)
`endif

`endif

FILE: design/bnfa_pkg.sv
// Types and constants of the next-fit bitmap allocator.
package bnfa_pkg;

  localparam int unsigned UNIT_W  = 16;
  localparam int unsigned INDEX_W = 15;

  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_MARK  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  localparam logic [UNIT_W-1:0] TOTAL_UNITS_RST = 16'd32768;

endpackage

FILE: design/bnfa_channels.sv
// Request and response channel interfaces of the allocator.
interface bnfa_req_if;
  import bnfa_pkg::*;

  logic               valid;
  logic               ready;
  cmd_t               cmd;
  logic [INDEX_W-1:0] unit_index;

  modport source (output valid, output cmd, output unit_index, input ready);
  modport sink   (input valid, input cmd, input unit_index, output ready);
endinterface

interface bnfa_rsp_if;
  import bnfa_pkg::*;

  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] granted_unit;
  status_t            status;
  logic [UNIT_W-1:0]  free_units;

  modport source (output valid, output granted_unit, output status, output free_units,
                  input ready);
  modport sink   (input valid, input granted_unit, input status, input free_units,
                  output ready);
endinterface

FILE: design/bnfa_bitmap_mem.sv
// Bitmap word store: one write port, one read port with registered data.
module bnfa_bitmap_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = 10
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: design/bitmap_next_fit_allocator.sv
// Next-fit allocator top level: controller around the bitmap word store.
// A mark, or an allocate that hits in the rover's word, is answered from the word read on acceptance;
// else each further bitmap word is read in turn, one read per cycle, until a free unit or the limit.
// The result is registered once the output is free; items are taken one at a time, in idle only.
// Reset: a clearing pass writes zero to every bitmap word, one word a cycle,
// with the request side not ready meanwhile.
`include "bitmap_next_fit_allocator_defines.svh"

module bitmap_next_fit_allocator #(
  parameter int unsigned MAX_UNITS = 32768,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [bnfa_pkg::UNIT_W-1:0] cfg_wr_data,
  bnfa_req_if.sink                  req,
  bnfa_rsp_if.source                rsp
);
  import bnfa_pkg::*;

  // Physical words are rounded up to a power of two; the bitmap semantics are unchanged.
  localparam int unsigned BIT_W = $clog2(WORD_BITS);
  localparam int unsigned PW    = 1 << BIT_W;
  localparam int unsigned DEPTH = (MAX_UNITS + PW - 1) / PW;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW    = UNIT_W + 1;
  localparam int unsigned WW    = SW - BIT_W;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL
  } state_t;

  state_t               state;
  logic [AW-1:0]        clr_addr;
  logic [UNIT_W-1:0]    total_units;
  logic [UNIT_W-1:0]    rover;
  logic [UNIT_W-1:0]    used_count;
  cmd_t                 cmd_q;
  logic [INDEX_W-1:0]   idx_q;
  logic [SW-1:0]        scan;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [PW-1:0]        mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [PW-1:0]        mem_rdata;

  logic [UNIT_W-1:0]    lim;
  logic [WW-1:0]        scan_word;
  logic [BIT_W-1:0]     scan_off;
  logic [WW-1:0]        lim_word;
  logic [BIT_W-1:0]     lim_off;
  logic [PW-1:0]        lo_mask;
  logic [PW-1:0]        hi_mask;
  logic [PW-1:0]        cand;
  logic                 found;
  logic [BIT_W-1:0]     ff_off;
  logic [SW-1:0]        alloc_unit;
  logic                 scan_end;
  logic [BIT_W-1:0]     idx_off;
  logic                 idx_used;
  logic                 idx_in_range;
  logic                 out_free;
  logic                 accept;
  logic                 finish;
  logic                 step;
  logic [UNIT_W-1:0]    rover_next;
  logic [UNIT_W-1:0]    used_next;
  logic [INDEX_W-1:0]   granted_next;
  status_t              status_next;
  logic [UNIT_W-1:0]    free_next;

  bnfa_bitmap_mem #(
    .DEPTH (DEPTH),
    .WIDTH (PW),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign lim = ({1'b0, total_units} > SW'(MAX_UNITS)) ? UNIT_W'(MAX_UNITS) : total_units;

  assign scan_word = scan[SW-1:BIT_W];
  assign scan_off  = scan[BIT_W-1:0];
  assign lim_word  = WW'(lim >> BIT_W);
  assign lim_off   = lim[BIT_W-1:0];
  assign lo_mask   = {PW{1'b1}} << scan_off;
  // Units at or above the limit count as unavailable in the limit's own word.
  assign hi_mask   = (scan_word == lim_word) ? ~({PW{1'b1}} << lim_off) : {PW{1'b1}};
  assign cand      = ~mem_rdata & lo_mask & hi_mask;
  assign found     = |cand;
  assign scan_end  = (scan >= {1'b0, lim});

  always_comb begin
    ff_off = '0;
    for (int k = PW - 1; k >= 0; k--) begin
      if (cand[k]) begin
        ff_off = BIT_W'(k);
      end
    end
  end

  assign alloc_unit   = {scan_word, ff_off};
  assign idx_off      = idx_q[BIT_W-1:0];
  assign idx_used     = mem_rdata[idx_off];
  assign idx_in_range = ({1'b0, idx_q} < lim);

  assign out_free = !rsp.valid || rsp.ready;
  assign accept   = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);

  // Finish when the answer is known and the output register can take it.
  always_comb begin
    finish = 1'b0;
    step   = 1'b0;
    if (state == ST_EVAL) begin
      if (cmd_q == CMD_MARK || scan_end || found) begin
        finish = out_free;
      end else begin
        step = 1'b1;
      end
    end
  end

  always_comb begin
    rover_next   = rover;
    used_next    = used_count;
    granted_next = '0;
    status_next  = STATUS_OK;
    mem_we       = 1'b0;
    mem_waddr    = scan_word[AW-1:0];
    mem_wdata    = mem_rdata;
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (cmd_q == CMD_ALLOC) begin
      if (scan_end) begin
        status_next = STATUS_FULL;
        rover_next  = (rover < lim) ? lim : rover;
      end else begin
        granted_next = alloc_unit[INDEX_W-1:0];
        rover_next   = alloc_unit[UNIT_W-1:0] + 1'b1;
        used_next    = used_count + 1'b1;
        mem_we       = finish;
        mem_wdata    = mem_rdata | (PW'(1) << ff_off);
      end
    end else begin
      mem_waddr = AW'(idx_q >> BIT_W);
      if (!idx_in_range) begin
        status_next = STATUS_RANGE;
      end else begin
        granted_next = idx_q;
        if (!idx_used) begin
          used_next = used_count + 1'b1;
          mem_we    = finish;
          mem_wdata = mem_rdata | (PW'(1) << idx_off);
        end
      end
    end
    free_next = (used_next >= lim) ? '0 : lim - used_next;
  end

  // Read address: in idle the incoming mark's word or the rover's word, the next word while scanning, else hold.
  always_comb begin
    if (state == ST_IDLE) begin
      if (req.cmd == CMD_MARK) begin
        mem_raddr = AW'(req.unit_index >> BIT_W);
      end else begin
        mem_raddr = AW'(rover >> BIT_W);
      end
    end else if (step) begin
      mem_raddr = AW'(scan_word + 1'b1);
    end else if (cmd_q == CMD_MARK) begin
      mem_raddr = AW'(idx_q >> BIT_W);
    end else begin
      mem_raddr = scan_word[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      total_units <= TOTAL_UNITS_RST;
      rover       <= '0;
      used_count  <= '0;
      rsp.valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        total_units <= cfg_wr_data;
      end
      if (finish) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cmd_q <= req.cmd;
            idx_q <= req.unit_index;
            scan  <= {1'b0, rover};
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (step) begin
            // Advance to the start of the next word.
            scan <= {scan_word + 1'b1, {BIT_W{1'b0}}};
          end else if (finish) begin
            rover            <= rover_next;
            used_count       <= used_next;
            rsp.granted_unit <= granted_next;
            rsp.status       <= status_next;
            rsp.free_units   <= free_next;
            state            <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `BNFA_ASSERT_RST(a_reset_clears, rst |=> (state == ST_CLEAR), "reset must start clearing")
  `BNFA_ASSERT(a_accept_eval, accept |=> (state == ST_EVAL), "accepted item must be evaluated")
  `BNFA_ASSERT(a_write_state, mem_we |-> (state == ST_EVAL || state == ST_CLEAR),
               "bitmap written outside clear or evaluation")
  `BNFA_ASSERT(a_count_on_set,
               (mem_we && state == ST_EVAL) |=> (used_count == $past(used_count) + 16'd1),
               "setting a bit must count one unit")
  `BNFA_ASSERT(a_fail_zero, (rsp.valid && rsp.status != STATUS_OK) |-> (rsp.granted_unit == '0),
               "failed result must grant zero")

endmodule
